[sv/base64_field_decoder_assert.svh]
// Assertion macros used by the base64 field decoder back end.
`ifndef BASE64_FIELD_DECODER_ASSERT_SVH
`define BASE64_FIELD_DECODER_ASSERT_SVH

// Same-cycle implication, clocked by clk_i and disabled in reset.
`define B64FD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("base64 field decoder assertion failed");

// Next-cycle implication, clocked by clk_i and disabled in reset.
`define B64FD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("base64 field decoder assertion failed");

`endif

[sv/b64fd_pkg.sv]
// Types, constants and the character classifier of the base64 field decoder.
`default_nettype none

package b64fd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam logic [15:0] CapacityReset = 16'd256;

  localparam logic [7:0] QuoteChar = 8'h22;
  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  typedef enum logic [1:0] {
    OP_DIGIT = 2'd0,
    OP_PAD   = 2'd1,
    OP_QUOTE = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    op_e        kind;
    logic [5:0] value;
  } op_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

  function automatic op_t classify(input logic [7:0] c);
    op_t r;
    r.kind  = OP_BAD;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.kind  = OP_DIGIT;
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.kind  = OP_DIGIT;
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.kind  = OP_DIGIT;
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == PlusChar) begin
      r.kind  = OP_DIGIT;
      r.value = 6'd62;
    end else if (c == SlashChar) begin
      r.kind  = OP_DIGIT;
      r.value = 6'd63;
    end else if (c == PadChar) begin
      r.kind = OP_PAD;
    end else if (c == QuoteChar) begin
      r.kind = OP_QUOTE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/b64fd_fifo.sv]
// Short queue of classified characters between the front and back ends.
`default_nettype none

module b64fd_fifo #(
  parameter int unsigned Depth = b64fd_pkg::QueueDepth
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  b64fd_pkg::op_t        wdata_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output b64fd_pkg::head_t      head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  b64fd_pkg::op_t mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[sv/b64fd_front.sv]
// Front end: accepts characters and classifies them into queue entries.
`default_nettype none

module b64fd_front (
  input  wire              in_valid_i,
  input  wire  [7:0]       char_in_i,
  output logic             in_stall_o,
  input  wire              q_full_i,
  output logic             q_push_o,
  output b64fd_pkg::op_t   q_op_o
);

  // A word is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_op_o     = b64fd_pkg::classify(char_in_i);

endmodule

`default_nettype wire

[sv/b64fd_back.sv]
// Back end: field state, capacity register and the result register.
`default_nettype none
`include "base64_field_decoder_assert.svh"

module b64fd_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [15:0]       cfg_wdata_i,
  input  b64fd_pkg::head_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [1:0]        result_kind_o,
  output logic [7:0]        data_byte_o,
  output logic [15:0]       length_o
);

  logic [15:0] cap_q;
  logic [11:0] acc_q, acc_d;
  logic [3:0]  bcnt_q, bcnt_d, bsum;
  logic [1:0]  gpos_q, gpos_d, pad_q, pad_d, need;
  logic [15:0] ocnt_q, ocnt_d;
  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [15:0] len_q;
  logic        res_valid;
  b64fd_pkg::kind_e res_kind;
  logic [7:0]  res_byte;
  logic [15:0] res_len;
  logic        full, bad;

  // One queue entry is retired per cycle unless a stalled result is held.
  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);

  assign need = 2'(~gpos_q + 2'd1);
  assign bad  = err_q || (cap_q == 16'd0) || (gpos_q == 2'd1) ||
                ((pad_q != 2'd0) && (pad_q != need));
  assign full = (cap_q == 16'd0) || (ocnt_q >= cap_q - 16'd1);
  assign bsum = bcnt_q + 4'd6;

  always_comb begin
    acc_d     = acc_q;
    bcnt_d    = bcnt_q;
    gpos_d    = gpos_q;
    pad_d     = pad_q;
    ocnt_d    = ocnt_q;
    err_d     = err_q;
    res_valid = 1'b0;
    res_kind  = b64fd_pkg::KIND_DATA;
    res_byte  = 8'd0;
    res_len   = 16'd0;
    if (pop_o) begin
      unique case (head_i.op.kind)
        b64fd_pkg::OP_QUOTE: begin
          res_valid = 1'b1;
          if (bad) begin
            res_kind = b64fd_pkg::KIND_ERROR;
          end else begin
            res_kind = b64fd_pkg::KIND_DONE;
            res_len  = ocnt_q;
          end
          acc_d  = '0;
          bcnt_d = '0;
          gpos_d = '0;
          pad_d  = '0;
          ocnt_d = '0;
          err_d  = 1'b0;
        end
        b64fd_pkg::OP_PAD: begin
          if (!err_q && pad_q != 2'd3) begin
            pad_d = pad_q + 2'd1;
          end
        end
        b64fd_pkg::OP_BAD: begin
          err_d = 1'b1;
        end
        b64fd_pkg::OP_DIGIT: begin
          if (!err_q) begin
            if (pad_q != 2'd0) begin
              err_d = 1'b1;
            end else begin
              gpos_d = gpos_q + 2'd1;
              acc_d  = {acc_q[5:0], head_i.op.value};
              if (bsum >= 4'd8) begin
                bcnt_d = bsum - 4'd8;
                if (full) begin
                  err_d = 1'b1;
                end else begin
                  res_valid = 1'b1;
                  res_byte  = 8'(acc_d >> bcnt_d);
                  ocnt_d    = ocnt_q + 16'd1;
                end
              end else begin
                bcnt_d = bsum;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= b64fd_pkg::CapacityReset;
      acc_q       <= '0;
      bcnt_q      <= '0;
      gpos_q      <= '0;
      pad_q       <= '0;
      ocnt_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      acc_q       <= acc_d;
      bcnt_q      <= bcnt_d;
      gpos_q      <= gpos_d;
      pad_q       <= pad_d;
      ocnt_q      <= ocnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      kind_q <= res_kind;
      byte_q <= res_byte;
      len_q  <= res_len;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign data_byte_o   = byte_q;
  assign length_o      = len_q;

  `B64FD_ASSERT_NEXT(a_quote_gives_end, pop_o && head_i.op.kind == b64fd_pkg::OP_QUOTE,
                     out_valid_q && kind_q != b64fd_pkg::KIND_DATA)
  `B64FD_ASSERT_NEXT(a_err_silent, pop_o && err_q && head_i.op.kind != b64fd_pkg::OP_QUOTE,
                     !out_valid_q)
  `B64FD_ASSERT_IMPL(a_data_no_len, out_valid_q && kind_q == b64fd_pkg::KIND_DATA,
                     len_q == 16'd0)
  `B64FD_ASSERT_NEXT(a_quote_clears, pop_o && head_i.op.kind == b64fd_pkg::OP_QUOTE,
                     ocnt_q == 16'd0 && !err_q && gpos_q == 2'd0)

endmodule

`default_nettype wire

[sv/base64_field_decoder.sv]
// Top level of the base64 field decoder: front end, queue and back end.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   char_in_i
//   out       output     out_valid_o / out_stall_i result_kind_o, data_byte_o, length_o
//   cfg       input      cfg_we_i                  cfg_wdata_i (capacity)
//
// One character word is taken every cycle while the queue has room; the back end
// retires one queue entry per cycle while the result register is free or being taken.
// An accepted character is queued; any result is registered when its entry is popped.
// Reset sets capacity to 256 and clears the field state; no clearing pass is needed.
// An output stall fills the queue of QueueDepth entries before the input stalls.
`default_nettype none

module base64_field_decoder #(
  parameter int unsigned QueueDepth = b64fd_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  char_in_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] length_o
);

  logic             q_full, q_push, q_pop;
  b64fd_pkg::op_t   q_op;
  b64fd_pkg::head_t q_head;

  b64fd_front u_front (
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (q_op)
  );

  b64fd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  b64fd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .data_byte_o   (data_byte_o),
    .length_o      (length_o)
  );

endmodule

`default_nettype wire
